// File: sv/arp_cache_aging_table_unit_defines.svh
// assertion macros for the arp cache block
`ifndef ARP_CACHE_AGING_TABLE_UNIT_DEFINES_SVH
`define ARP_CACHE_AGING_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/arpc_pkg.sv
// shared constants and controller/datapath types for the arp cache
package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = 4;
    localparam int AGE_W   = 16;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(30);

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic capture;     // latch the request and clear the scan trackers
        logic scan_issue;  // read the entry at the scan counter
        logic finish;      // write the table on update and load the result
    } cmd_t;

    typedef struct packed {
        logic issue_last;  // scan counter sits on the last entry
        logic out_free;    // result register can take a new result
    } status_t;

endpackage

// File: sv/arpc_ctrl.sv
// sequencer for request capture, table scan and result hand-off
module arpc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  arpc_pkg::status_t status,
    output arpc_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.scan_issue = 1'b0;
        cmd.finish     = 1'b0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // last entry read is evaluated here
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/arpc_dpath.sv
// table storage, ageing scan, slot selection and result register
module arpc_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  arpc_pkg::cmd_t                cmd,
    output arpc_pkg::status_t             status,
    input  logic                          s_op,
    input  logic [arpc_pkg::IP_W-1:0]     s_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]    s_mac_address,
    input  logic [arpc_pkg::TIME_W-1:0]   s_now_seconds,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arpc_pkg::AGE_W-1:0]    cfg_age_limit_seconds,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [arpc_pkg::MAC_W-1:0]    m_mac_result,
    output logic [arpc_pkg::SLOT_W-1:0]   m_slot,
    output logic                          m_evicted
);

    localparam int IDX_W = arpc_pkg::IDX_W;

    // table
    logic [arpc_pkg::IP_W-1:0]   ip_mem    [arpc_pkg::ENTRIES];
    logic [arpc_pkg::MAC_W-1:0]  mac_mem   [arpc_pkg::ENTRIES];
    logic [arpc_pkg::TIME_W-1:0] stamp_mem [arpc_pkg::ENTRIES];
    logic [arpc_pkg::ENTRIES-1:0] valid_reg;

    logic [arpc_pkg::AGE_W-1:0] age_limit_reg;

    // latched request
    logic                        op_reg;
    logic [arpc_pkg::IP_W-1:0]   ip_reg;
    logic [arpc_pkg::MAC_W-1:0]  mac_reg;
    logic [arpc_pkg::TIME_W-1:0] now_reg;

    // scan
    logic [IDX_W-1:0]            cnt_reg;
    logic                        s1_valid_reg;
    logic [IDX_W-1:0]            s1_idx_reg;
    logic [arpc_pkg::IP_W-1:0]   rd_ip_reg;
    logic [arpc_pkg::MAC_W-1:0]  rd_mac_reg;
    logic [arpc_pkg::TIME_W-1:0] rd_stamp_reg;

    // trackers: first matching (lookup) or first free (update) entry, and oldest entry
    logic                        sel_found_reg;
    logic [IDX_W-1:0]            sel_idx_reg;
    logic [arpc_pkg::MAC_W-1:0]  sel_mac_reg;
    logic [arpc_pkg::TIME_W-1:0] best_age_reg;
    logic [IDX_W-1:0]            best_idx_reg;

    // result register
    logic                        m_valid_reg;
    logic                        m_found_reg;
    logic [arpc_pkg::MAC_W-1:0]  m_mac_reg;
    logic [arpc_pkg::SLOT_W-1:0] m_slot_reg;
    logic                        m_evicted_reg;

    logic [arpc_pkg::TIME_W-1:0] age;
    logic                        too_old;
    logic                        entry_live;
    logic                        hit;
    logic [IDX_W-1:0]            target;
    logic [IDX_W-1:0]            res_idx;
    logic [IDX_W+arpc_pkg::SLOT_W-1:0] res_idx_wide;
    logic                        is_lookup;

    assign cfg_ready = 1'b1;
    assign is_lookup = (op_reg == arpc_pkg::OP_LOOKUP);

    // wrapping age of the entry under evaluation
    assign age        = now_reg - rd_stamp_reg;
    assign too_old    = age > {{(arpc_pkg::TIME_W-arpc_pkg::AGE_W){1'b0}}, age_limit_reg};
    assign entry_live = valid_reg[s1_idx_reg] && (is_lookup || !too_old);
    assign hit        = is_lookup ? (entry_live && (rd_ip_reg == ip_reg)) : !entry_live;

    assign target = sel_found_reg ? sel_idx_reg : best_idx_reg;

    // slot is reported modulo the field width
    assign res_idx      = is_lookup ? (sel_found_reg ? sel_idx_reg : '0) : target;
    assign res_idx_wide = {{arpc_pkg::SLOT_W{1'b0}}, res_idx};

    assign status.issue_last = (cnt_reg == IDX_W'(arpc_pkg::ENTRIES - 1));
    assign status.out_free   = !m_valid_reg || m_ready;

    // memories: one read per scan cycle, one write at finish
    always_ff @(posedge aclk) begin
        if (cmd.scan_issue) begin
            rd_ip_reg    <= ip_mem[cnt_reg];
            rd_mac_reg   <= mac_mem[cnt_reg];
            rd_stamp_reg <= stamp_mem[cnt_reg];
        end
        if (cmd.finish && !is_lookup) begin
            ip_mem[target]    <= ip_reg;
            mac_mem[target]   <= mac_reg;
            stamp_mem[target] <= now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            age_limit_reg <= arpc_pkg::AGE_LIMIT_RESET;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                age_limit_reg <= cfg_age_limit_seconds;
            end
            s1_valid_reg <= cmd.scan_issue;
            if (s1_valid_reg && !is_lookup && too_old) begin
                valid_reg[s1_idx_reg] <= 1'b0;
            end
            if (cmd.finish && !is_lookup) begin
                valid_reg[target] <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg        <= s_op;
            ip_reg        <= s_ip_address;
            mac_reg       <= s_mac_address;
            now_reg       <= s_now_seconds;
            cnt_reg       <= '0;
            sel_found_reg <= 1'b0;
            sel_idx_reg   <= '0;
            sel_mac_reg   <= '0;
            best_age_reg  <= '0;
            best_idx_reg  <= '0;
        end else begin
            if (cmd.scan_issue) begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            if (cmd.scan_issue) begin
                s1_idx_reg <= cnt_reg;
            end
            if (s1_valid_reg) begin
                if (hit && !sel_found_reg) begin
                    sel_found_reg <= 1'b1;
                    sel_idx_reg   <= s1_idx_reg;
                    sel_mac_reg   <= rd_mac_reg;
                end
                // strictly older wins, so ties keep the lower index
                if (age > best_age_reg) begin
                    best_age_reg <= age;
                    best_idx_reg <= s1_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_found_reg   <= is_lookup ? sel_found_reg : 1'b1;
            m_mac_reg     <= (is_lookup && sel_found_reg) ? sel_mac_reg : '0;
            m_slot_reg    <= res_idx_wide[arpc_pkg::SLOT_W-1:0];
            m_evicted_reg <= !is_lookup && !sel_found_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_mac_result = m_mac_reg;
    assign m_slot       = m_slot_reg;
    assign m_evicted    = m_evicted_reg;

endmodule

// File: sv/arp_cache_aging_table_unit.sv
// arp cache top level: sequencer plus table datapath
// An ARP cache of 16 entries mapping IPv4 to MAC addresses, one request at a time. Each
// request (update or lookup) walks the whole table through the single read port of the
// entry memory, one entry per cycle: it reads the entries, settles the last read, then
// writes the chosen entry on an update and loads the result register. The next request
// is taken only once the block is back in idle, so a new request is never taken before
// the last one is through. An update ages the table in that same pass, dropping entries
// older than the age limit, then fills the first free entry or, when none is free,
// overwrites the oldest. A lookup reports the first valid match without checking age.
// The next request is taken while a result still waits to be read; if that result is
// still waiting when the next one is ready, the block holds in its last step until the
// result is taken.
`include "arp_cache_aging_table_unit_defines.svh"

module arp_cache_aging_table_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [arpc_pkg::IP_W-1:0]     s_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]    s_mac_address,
    input  logic [arpc_pkg::TIME_W-1:0]   s_now_seconds,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [arpc_pkg::MAC_W-1:0]    m_mac_result,
    output logic [arpc_pkg::SLOT_W-1:0]   m_slot,
    output logic                          m_evicted,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arpc_pkg::AGE_W-1:0]    cfg_age_limit_seconds
);

    arpc_pkg::cmd_t    cmd;
    arpc_pkg::status_t status;

    arpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    arpc_dpath u_dpath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .s_op                  (s_op),
        .s_ip_address          (s_ip_address),
        .s_mac_address         (s_mac_address),
        .s_now_seconds         (s_now_seconds),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_age_limit_seconds (cfg_age_limit_seconds),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_found               (m_found),
        .m_mac_result          (m_mac_result),
        .m_slot                (m_slot),
        .m_evicted             (m_evicted)
    );

    // a request occupies the block for the whole scan
    `ARPC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "request taken while busy")
    // a missed lookup reports slot zero and no mac
    `ARPC_ASSERT_NOW(a_miss_is_clean, m_valid && !m_found, (m_mac_result == '0) && (m_slot == '0) && !m_evicted, "lookup miss carries data")
    // eviction only comes from an update, which always reports found
    `ARPC_ASSERT_NOW(a_evict_found, m_valid && m_evicted, m_found && (m_mac_result == '0), "eviction on bad result")

endmodule

// File: tb/arp_cache_aging_table_unit_tb.sv
// self-checking testbench for the arp cache ageing table
module arp_cache_aging_table_unit_tb;

    localparam int ENTRIES       = arpc_pkg::ENTRIES;
    localparam int SLOT_W        = arpc_pkg::SLOT_W;
    localparam int AGE_W         = arpc_pkg::AGE_W;
    localparam int IP_W          = arpc_pkg::IP_W;
    localparam int MAC_W         = arpc_pkg::MAC_W;
    localparam int TIME_W        = arpc_pkg::TIME_W;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int QUIET_START   = 4000;
    localparam int QUIET_END     = 9000;
    localparam int IP_POOL_SIZE  = 24;
    localparam int PHASE_ITEMS   = 175;
    localparam int PHASES        = 6;

    typedef struct packed {
        logic              op;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
    } arp_request_t;

    typedef struct packed {
        logic              found;
        logic [MAC_W-1:0]  mac_result;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } arp_answer_t;

    typedef struct packed {
        arp_request_t req;
        logic         pinned;
        arp_answer_t  pin;
    } directed_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_op = arpc_pkg::OP_UPDATE;
    logic [IP_W-1:0]     s_ip_address = '0;
    logic [MAC_W-1:0]    s_mac_address = '0;
    logic [TIME_W-1:0]   s_now_seconds = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_found;
    logic [MAC_W-1:0]    m_mac_result;
    logic [SLOT_W-1:0]   m_slot;
    logic                m_evicted;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [AGE_W-1:0]    cfg_age_limit_seconds = '0;

    // shadow table and register
    logic                table_valid [ENTRIES];
    logic [IP_W-1:0]     table_ip    [ENTRIES];
    logic [MAC_W-1:0]    table_mac   [ENTRIES];
    logic [TIME_W-1:0]   table_stamp [ENTRIES];
    logic [AGE_W-1:0]    age_limit;

    arp_answer_t         pending_answers [$];
    directed_row_t       directed_rows [$];
    logic [IP_W-1:0]     ip_pool [IP_POOL_SIZE];
    logic [TIME_W-1:0]   wall_clock;
    arp_answer_t         monitor_want;
    int unsigned         gap_ahead = 0;
    int unsigned         cycle_count = 0;
    int unsigned         errors = 0;

    wire quiet_window = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    arp_cache_aging_table_unit u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_op                  (s_op),
        .s_ip_address          (s_ip_address),
        .s_mac_address         (s_mac_address),
        .s_now_seconds         (s_now_seconds),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_found               (m_found),
        .m_mac_result          (m_mac_result),
        .m_slot                (m_slot),
        .m_evicted             (m_evicted),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_age_limit_seconds (cfg_age_limit_seconds)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("arp_cache_aging_table_unit verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= quiet_window || ($urandom_range(0, 99) >= 28);
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[MAC_W-1:0];
    endfunction

    // for an update, ages the shadow table and places the address; for a lookup, finds it
    function automatic arp_answer_t resolve_request(input arp_request_t r);
        arp_answer_t       res;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        int                target;
        bit                have_free;
        res = '0;
        if (r.op == arpc_pkg::OP_LOOKUP) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (table_valid[i] && table_ip[i] == r.ip) begin
                    res.found = 1'b1;
                    res.mac_result = table_mac[i];
                    res.slot = SLOT_W'(i);
                    return res;
                end
            end
            return res;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            age = r.now - table_stamp[i];
            if (age > age_limit) table_valid[i] = 1'b0;
        end
        target = 0;
        have_free = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!have_free && !table_valid[i]) begin
                target = i;
                have_free = 1'b1;
            end
        end
        if (!have_free) begin
            // strictly older wins, so ties stay on the lowest index
            oldest = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                age = r.now - table_stamp[i];
                if (age > oldest) begin
                    oldest = age;
                    target = i;
                end
            end
            res.evicted = 1'b1;
        end
        table_valid[target] = 1'b1;
        table_stamp[target] = r.now;
        table_ip[target] = r.ip;
        table_mac[target] = r.mac;
        res.found = 1'b1;
        res.slot = SLOT_W'(target);
        return res;
    endfunction

    task automatic add_row(input logic op, input logic [IP_W-1:0] ip,
                           input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] now,
                           input logic pinned, input logic found,
                           input logic [MAC_W-1:0] mac_result,
                           input logic [SLOT_W-1:0] slot, input logic evicted);
        directed_row_t row;
        row.req = '{op: op, ip: ip, mac: mac, now: now};
        row.pinned = pinned;
        row.pin = '{found: found, mac_result: mac_result, slot: slot, evicted: evicted};
        directed_rows.push_back(row);
    endtask

    // valid stays up across back-to-back requests, dropped before a gap or after the last request
    task automatic issue_request(input arp_request_t r, input logic pinned,
                                 input arp_answer_t pin, input bit more);
        arp_answer_t predicted;
        repeat (gap_ahead) @(posedge aclk);
        s_valid <= 1'b1;
        s_op <= r.op;
        s_ip_address <= r.ip;
        s_mac_address <= r.mac;
        s_now_seconds <= r.now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = resolve_request(r);
        pending_answers.push_back(pinned ? pin : predicted);
        gap_ahead = (!quiet_window && $urandom_range(0, 99) < 28) ? $urandom_range(1, 24) : 0;
        if (!more || gap_ahead != 0) s_valid <= 1'b0;
    endtask

    task automatic set_age_limit(input logic [AGE_W-1:0] value);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_age_limit_seconds <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        age_limit = value;
    endtask

    task automatic random_burst(input int count);
        arp_request_t r;
        int           pick;
        for (int k = 0; k < count; k++) begin
            r.op = ($urandom_range(0, 99) < 45) ? arpc_pkg::OP_LOOKUP : arpc_pkg::OP_UPDATE;
            r.ip = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, IP_POOL_SIZE - 1)]
                                                : $urandom;
            r.mac = random_mac();
            if (r.op == arpc_pkg::OP_UPDATE) begin
                // mostly small steps so the table fills up inside the age limit
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    wall_clock = wall_clock + $urandom_range(0, 2);
                else if (pick < 90)
                    wall_clock = wall_clock + $urandom_range(0, age_limit / 8 + 3);
                else if (pick < 96)
                    wall_clock = wall_clock + age_limit + $urandom_range(0, 2);
                else if (pick < 98)
                    wall_clock = $urandom;
                else
                    wall_clock = wall_clock - $urandom_range(1, 5);
                r.now = wall_clock;
            end else begin
                r.now = $urandom;
            end
            issue_request(r, 1'b0, '0, k != count - 1);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
            end else begin
                monitor_want = pending_answers.pop_front();
                if (m_found !== monitor_want.found) begin
                    $error("found: expected %0d, got %0d", monitor_want.found, m_found);
                    errors++;
                end
                if (m_mac_result !== monitor_want.mac_result) begin
                    $error("mac_result: expected %h, got %h", monitor_want.mac_result,
                           m_mac_result);
                    errors++;
                end
                if (m_slot !== monitor_want.slot) begin
                    $error("slot: expected %0d, got %0d", monitor_want.slot, m_slot);
                    errors++;
                end
                if (m_evicted !== monitor_want.evicted) begin
                    $error("evicted: expected %0d, got %0d", monitor_want.evicted, m_evicted);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [AGE_W-1:0] age_plan [PHASES];
        age_limit = arpc_pkg::AGE_LIMIT_RESET;
        for (int i = 0; i < ENTRIES; i++) begin
            table_valid[i] = 1'b0;
            table_ip[i] = '0;
            table_mac[i] = '0;
            table_stamp[i] = '0;
        end
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < IP_POOL_SIZE; i++) ip_pool[i] = $urandom;

        // lookup miss on an empty table, then the field extremes
        add_row(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 1'b1,
                1'b0, '0, 4'd0, 1'b0);
        add_row(arpc_pkg::OP_UPDATE, 32'h0000_0000, '1, 32'h0, 1'b1, 1'b1, '0, 4'd0, 1'b0);
        add_row(arpc_pkg::OP_UPDATE, 32'hFFFF_FFFF, '0, 32'h0, 1'b1, 1'b1, '0, 4'd1, 1'b0);
        add_row(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 48'h5A5A_5A5A_5A5A, 32'h0, 1'b1,
                1'b1, '0, 4'd1, 1'b0);
        add_row(arpc_pkg::OP_LOOKUP, 32'h0000_0000, 48'hA5A5_A5A5_A5A5, 32'h7, 1'b1,
                1'b1, '1, 4'd0, 1'b0);
        // age exactly at the limit survives, one past it does not
        add_row(arpc_pkg::OP_UPDATE, 32'hC0A8_0001, 48'h0200_0000_0001, 32'd30, 1'b0,
                1'b0, '0, '0, 1'b0);
        add_row(arpc_pkg::OP_UPDATE, 32'hC0A8_0001, 48'h0200_0000_0002, 32'd31, 1'b0,
                1'b0, '0, '0, 1'b0);
        // duplicate addresses: the first valid copy answers
        add_row(arpc_pkg::OP_LOOKUP, 32'hC0A8_0001, '0, 32'd31, 1'b0, 1'b0, '0, '0, 1'b0);
        // clock running backwards ages everything out
        add_row(arpc_pkg::OP_UPDATE, 32'h0A00_0001, 48'h0200_0000_0003, 32'd5, 1'b0,
                1'b0, '0, '0, 1'b0);
        for (int i = 0; i < ENTRIES; i++)
            add_row(arpc_pkg::OP_UPDATE, 32'h0A00_0010 + IP_W'(i),
                    48'h0200_0000_0100 + MAC_W'(i), 32'hFFFF_FFFF,
                    1'b0, 1'b0, '0, '0, 1'b0);
        // full table with equal ages evicts entry 0
        add_row(arpc_pkg::OP_UPDATE, 32'h0A00_00FF, 48'h0200_0000_00FF, 32'hFFFF_FFFF, 1'b1,
                1'b1, '0, 4'd0, 1'b1);
        add_row(arpc_pkg::OP_LOOKUP, 32'h0A00_0015, '0, 32'h0, 1'b0, 1'b0, '0, '0, 1'b0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < directed_rows.size(); i++)
            issue_request(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].pin,
                          i != directed_rows.size() - 1);

        age_plan[0] = '1;
        age_plan[1] = '0;
        age_plan[2] = AGE_W'(7);
        age_plan[3] = AGE_W'($urandom_range(1, 65534));
        age_plan[4] = AGE_W'(1000);
        age_plan[5] = arpc_pkg::AGE_LIMIT_RESET;
        wall_clock = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            set_age_limit(age_plan[p]);
            random_burst(PHASE_ITEMS);
        end

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("arp_cache_aging_table_unit verification clean");
        else
            $display("arp_cache_aging_table_unit verification failed");
        $finish;
    end

endmodule
